[hw/rtl/duty_cycle_meter_hysteresis_switch_assert.svh]
// Assertion macros shared by the duty cycle meter RTL.
// No dependencies; included by modules that carry checks.
`ifndef DUTY_CYCLE_METER_HYSTERESIS_SWITCH_ASSERT_SVH
`define DUTY_CYCLE_METER_HYSTERESIS_SWITCH_ASSERT_SVH

// Clocked property check, disabled while reset is asserted (active low).
`define DCM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define DCM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `DCM_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

[hw/rtl/dcm_pkg.sv]
// Shared constants and types for the duty cycle meter.
// No dependencies; used by the interfaces and every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dcm_pkg;

  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned QUOT_BITS = 7;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [DUTY_W-1:0] PERCENT        = 7'd100;
  localparam logic [DUTY_W-1:0] LOW_THR_RESET  = 7'd15;
  localparam logic [DUTY_W-1:0] HIGH_THR_RESET = 7'd95;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_LOW_THR  = 1'b0;
  localparam logic REG_HIGH_THR = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } dcm_q_status_t;

endpackage

`default_nettype wire

[hw/rtl/dcm_if.sv]
// Valid/ready channel interfaces: PWM samples in, measurement results out.
// Depends on dcm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dcm_in_if;
  logic valid;
  logic ready;
  logic pwm_level;

  modport source (output valid, output pwm_level, input ready);
  modport sink   (input valid, input pwm_level, output ready);
endinterface

interface dcm_res_if;
  logic                        valid;
  logic                        ready;
  logic [dcm_pkg::DUTY_W-1:0]  duty_percent;
  logic [dcm_pkg::TICKS_W-1:0] high_ticks;
  logic [dcm_pkg::TICKS_W-1:0] period_ticks;
  logic                        pump_on;

  modport source (output valid, output duty_percent, output high_ticks,
                  output period_ticks, output pump_on, input ready);
  modport sink   (input valid, input duty_percent, input high_ticks,
                  input period_ticks, input pump_on, output ready);
endinterface

`default_nettype wire

[hw/rtl/dcm_front.sv]
// Front end: edge detection, phase tracking and tick counting per sample.
// Depends on dcm_pkg and dcm_if; pushes finished measurements to the queue.
`timescale 1ns / 1ps
`default_nettype none

module dcm_front #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  dcm_in_if.sink                          pwm_i,
  input  dcm_pkg::dcm_q_status_t          q_status_i,
  output logic                            push_o,
  output logic [2*COUNT_WIDTH-1:0]        push_data_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    WaitRise,
    WaitFall,
    WaitRise2
  } phase_e;

  phase_e                 phase_q;
  logic                   prev_q;
  logic [COUNT_WIDTH-1:0] tick_q;
  logic [COUNT_WIDTH-1:0] high_q;

  logic                   accept;
  logic                   rise;
  logic                   fall;
  logic                   at_max;
  logic [COUNT_WIDTH-1:0] tick_inc;

  // Stall samples only while the queue has no room for a result.
  assign pwm_i.ready = !q_status_i.full;
  assign accept      = pwm_i.valid && pwm_i.ready;

  assign rise     = !prev_q && pwm_i.pwm_level;
  assign fall     = prev_q && !pwm_i.pwm_level;
  assign at_max   = (tick_q == CountMax);
  assign tick_inc = tick_q + 1'b1;

  assign push_o      = accept && (phase_q == WaitRise2) && rise && !at_max;
  assign push_data_o = {high_q, tick_inc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= WaitRise;
      prev_q  <= 1'b1;
      tick_q  <= '0;
      high_q  <= '0;
    end else if (accept) begin
      prev_q <= pwm_i.pwm_level;
      case (phase_q)
        WaitRise: begin
          if (rise) begin
            tick_q  <= '0;
            phase_q <= WaitFall;
          end
        end
        WaitFall: begin
          if (at_max) begin
            // drop the measurement on counter overflow
            tick_q  <= '0;
            phase_q <= WaitRise;
          end else begin
            tick_q <= tick_inc;
            if (fall) begin
              high_q  <= tick_inc;
              phase_q <= WaitRise2;
            end
          end
        end
        WaitRise2: begin
          if (at_max) begin
            tick_q  <= '0;
            phase_q <= WaitRise;
          end else begin
            tick_q <= tick_inc;
            if (rise) begin
              phase_q <= WaitRise;
            end
          end
        end
        default: begin
          phase_q <= WaitRise;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dcm_fifo.sv]
// Two-entry queue of finished measurements between front and back end.
// Depends on dcm_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module dcm_fifo #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [WIDTH-1:0]  push_data_i,
  input  wire logic              pop_i,
  output logic [WIDTH-1:0]       pop_data_o,
  output dcm_pkg::dcm_q_status_t status_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dcm_back.sv]
// Back end: duty = high*100/period by a bit-serial divider, hysteresis flag,
// result register. Depends on dcm_pkg, dcm_if and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "duty_cycle_meter_hysteresis_switch_assert.svh"

module dcm_back #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  dcm_pkg::dcm_q_status_t             q_status_i,
  output logic                               pop_o,
  input  wire logic [2*COUNT_WIDTH-1:0]      pop_data_i,
  input  wire logic [dcm_pkg::DUTY_W-1:0]    low_thr_i,
  input  wire logic [dcm_pkg::DUTY_W-1:0]    high_thr_i,
  dcm_res_if.source                          res_o
);

  localparam int unsigned QB    = dcm_pkg::QUOT_BITS;
  localparam int unsigned ProdW = COUNT_WIDTH + QB;
  localparam int unsigned StepW = $clog2(QB);

  typedef enum logic [1:0] {
    Idle,
    Mul,
    Div,
    Fin
  } state_e;

  state_e                         state_q;
  logic [COUNT_WIDTH-1:0]         high_q;
  logic [COUNT_WIDTH-1:0]         period_q;
  logic [QB-1:0]                  low_bits_q;
  logic [COUNT_WIDTH-1:0]         rem_q;
  logic [QB-1:0]                  quot_q;
  logic [StepW-1:0]               step_q;
  logic                           refill_q;

  logic                           out_valid_q;
  logic [dcm_pkg::DUTY_W-1:0]     out_duty_q;
  logic [dcm_pkg::TICKS_W-1:0]    out_high_q;
  logic [dcm_pkg::TICKS_W-1:0]    out_period_q;
  logic                           out_pump_q;

  logic [ProdW-1:0]               product;
  logic [COUNT_WIDTH:0]           trial;
  logic [COUNT_WIDTH:0]           diff;
  logic                           fits;
  logic                           refill_d;
  logic                           out_free;
  logic                           out_load;
  logic [31:0]                    high_ext;
  logic [31:0]                    period_ext;

  assign pop_o = (state_q == Idle) && !q_status_i.empty;

  assign product = ProdW'(high_q) * ProdW'(dcm_pkg::PERCENT);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_q, low_bits_q[step_q]};
  assign diff  = trial - {1'b0, period_q};
  assign fits  = (trial >= {1'b0, period_q});

  // Low test first so overlapping thresholds favor refilling.
  always_comb begin
    refill_d = refill_q;
    if (quot_q <= low_thr_i) begin
      refill_d = 1'b1;
    end else if (quot_q >= high_thr_i) begin
      refill_d = 1'b0;
    end
  end

  assign out_free   = !out_valid_q || res_o.ready;
  assign out_load   = (state_q == Fin) && out_free;
  assign high_ext   = 32'(high_q);
  assign period_ext = 32'(period_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= Idle;
      refill_q     <= 1'b1;
      out_valid_q  <= 1'b0;
      step_q       <= '0;
      high_q       <= '0;
      period_q     <= '0;
      low_bits_q   <= '0;
      rem_q        <= '0;
      quot_q       <= '0;
      out_duty_q   <= '0;
      out_high_q   <= '0;
      out_period_q <= '0;
      out_pump_q   <= 1'b0;
    end else begin
      // Load a new word or drop the one just taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        Idle: begin
          if (!q_status_i.empty) begin
            high_q   <= pop_data_i[2*COUNT_WIDTH-1:COUNT_WIDTH];
            period_q <= pop_data_i[COUNT_WIDTH-1:0];
            state_q  <= Mul;
          end
        end
        Mul: begin
          // quotient is below 100, so only the low bits need dividing
          low_bits_q <= product[QB-1:0];
          rem_q      <= product[ProdW-1:QB];
          quot_q     <= '0;
          step_q     <= StepW'(QB - 1);
          state_q    <= Div;
        end
        Div: begin
          quot_q <= {quot_q[QB-2:0], fits};
          rem_q  <= fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
          if (step_q == '0) begin
            state_q <= Fin;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        Fin: begin
          if (out_free) begin
            refill_q     <= refill_d;
            out_duty_q   <= quot_q;
            out_high_q   <= high_ext[dcm_pkg::TICKS_W-1:0];
            out_period_q <= period_ext[dcm_pkg::TICKS_W-1:0];
            out_pump_q   <= refill_d;
            state_q      <= Idle;
          end
        end
        default: begin
          state_q <= Idle;
        end
      endcase
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.duty_percent = out_duty_q;
  assign res_o.high_ticks   = out_high_q;
  assign res_o.period_ticks = out_period_q;
  assign res_o.pump_on      = out_pump_q;

  `DCM_ASSERT(a_rem_below_period, clk_i, rst_ni, (state_q == Div) |-> (rem_q < period_q), "divider remainder reached the period")
  `DCM_ASSERT(a_pop_starts_mul, clk_i, rst_ni, pop_o |=> (state_q == Mul), "popped measurement did not start a multiply")
  `DCM_ASSERT_NEVER(a_duty_in_range, clk_i, rst_ni, res_o.valid && (res_o.duty_percent >= dcm_pkg::PERCENT), "duty result at or above 100")

endmodule

`default_nettype wire

[hw/rtl/duty_cycle_meter_hysteresis_switch.sv]
// Top level of the PWM duty cycle meter with hysteresis pump switch.
// Depends on dcm_pkg, dcm_if, dcm_front, dcm_fifo and dcm_back.
//
// Usage:
//   pwm_i carries one sampled pin level per word, one word per timer tick.
//   The block looks for a rise, a fall and the next rise, counting ticks
//   from the first rise, and then sends one word on res_o: duty percent
//   (high*100/period, truncated), high and period tick counts (low 16 bits)
//   and the pump flag after the hysteresis update.
//   Thresholds sit behind an APB-style port: low at byte 0, high at byte 4.
//   Throughput: one sample per cycle while the queue has room. The front end
//   counts ticks per sample; a result leaves the two-entry queue and passes
//   the back end steps in order (pop, multiply, 7 divider steps, result load).
//   A period is at least two samples long.
//   Receiver stall: the result register holds; the back end waits at its
//   load step; when the queue is full pwm_i.ready drops until space frees.
//   Counter overflow drops the measurement without a result.
//   Reset: thresholds return to 15 and 95, the internal pump flag is set, the
//   previous level reads high (a pin already high is no rise), queue empty.
`timescale 1ns / 1ps
`default_nettype none

module duty_cycle_meter_hysteresis_switch #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  dcm_in_if.sink                            pwm_i,
  dcm_res_if.source                         res_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dcm_pkg::APB_AW-1:0]   paddr,
  input  wire logic [dcm_pkg::APB_DW-1:0]   pwdata,
  output logic [dcm_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  logic [dcm_pkg::DUTY_W-1:0] low_thr_q;
  logic [dcm_pkg::DUTY_W-1:0] high_thr_q;
  logic                       cfg_wr;
  logic                       reg_sel;

  logic                       push;
  logic [2*COUNT_WIDTH-1:0]   push_data;
  logic                       pop;
  logic [2*COUNT_WIDTH-1:0]   pop_data;
  dcm_pkg::dcm_q_status_t     q_status;

  // Register select is the word address bit; byte offset bits are ignored.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      dcm_pkg::REG_LOW_THR:  prdata = dcm_pkg::APB_DW'(low_thr_q);
      dcm_pkg::REG_HIGH_THR: prdata = dcm_pkg::APB_DW'(high_thr_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= dcm_pkg::LOW_THR_RESET;
      high_thr_q <= dcm_pkg::HIGH_THR_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        dcm_pkg::REG_LOW_THR:  low_thr_q  <= pwdata[dcm_pkg::DUTY_W-1:0];
        dcm_pkg::REG_HIGH_THR: high_thr_q <= pwdata[dcm_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Classify samples and count ticks.
  dcm_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pwm_i       (pwm_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Hold finished measurements while the divider is busy.
  dcm_fifo #(
    .WIDTH (2 * COUNT_WIDTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // Divide, apply hysteresis and present the result word.
  dcm_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .low_thr_i  (low_thr_q),
    .high_thr_i (high_thr_q),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire
